/* design/mbd_pkg.sv */
// Shared types, constants and helpers for the multi-button debouncer.
// No dependencies; imported by every module of the block.
package mbd_pkg;

    localparam int NUM_BUTTONS_DEF = 8;
    localparam int LEVEL_BITS      = 8;
    localparam int TH_W            = 15;
    localparam int CNT_W           = 16;
    localparam int TIME_W          = 32;
    localparam int IDX_FIELD_W     = 8;
    localparam int S_DATA_W        = 48;
    localparam int M_DATA_W        = 72;

    localparam logic [TH_W-1:0] PRESS_TH_RST = 15'd20;
    localparam logic [TH_W-1:0] HOLD_TH_RST  = 15'd1000;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_HOLD    = 2'd2,
        EV_RELEASE = 2'd3
    } event_t;

    typedef enum logic {
        REG_PRESS_TH = 1'b0,
        REG_HOLD_TH  = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_READ = 1'b1
    } req_t;

    typedef struct packed {
        event_t              ev;
        logic [TIME_W-1:0]   chg_time;
        logic                act;
    } lane_stat_t;

    function automatic logic signed [CNT_W-1:0] sat16(input logic signed [CNT_W+1:0] v);
        logic signed [CNT_W-1:0] r;
        if (v > 18'sd32767)
            r = 16'sh7FFF;
        else if (v < -18'sd32768)
            r = 16'sh8000;
        else
            r = v[CNT_W-1:0];
        return r;
    endfunction

endpackage

/* design/mbd_lane.sv */
// One button's debounce core: event state, saturating counter, change time.
// Depends on mbd_pkg.
module mbd_lane
    import mbd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick_en,
    input  logic                read_clr,
    input  logic                pressed,
    input  logic [CNT_W-1:0]    d,
    input  logic [TIME_W-1:0]   now,
    input  logic [TH_W-1:0]     press_th,
    input  logic [TH_W-1:0]     hold_th,
    output lane_stat_t          stat
);

    event_t                   ev_reg, ev_next;
    logic signed [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TIME_W-1:0]        chg_reg, chg_next;
    logic signed [CNT_W+1:0]  sum, diff;
    logic signed [CNT_W-1:0]  pth, hth;
    logic                     act;

    assign pth  = signed'({1'b0, press_th});
    assign hth  = signed'({1'b0, hold_th});
    assign sum  = {{2{cnt_reg[CNT_W-1]}}, cnt_reg} + signed'({2'b00, d});
    assign diff = {{2{cnt_reg[CNT_W-1]}}, cnt_reg} - signed'({2'b00, d});

    always_comb
    begin
        ev_next  = ev_reg;
        cnt_next = cnt_reg;
        chg_next = chg_reg;
        if (tick_en)
        begin
            if (pressed)
            begin
                if (ev_reg == EV_NONE || ev_reg == EV_RELEASE)
                begin
                    cnt_next = sat16(sum);
                    if (cnt_next > pth)
                        ev_next = EV_PRESS;
                end
                else if (ev_reg == EV_PRESS)
                begin
                    cnt_next = sat16(sum);
                    if (cnt_next > hth)
                        ev_next = EV_HOLD;
                end
            end
            else if (ev_reg == EV_PRESS || ev_reg == EV_HOLD)
            begin
                if (cnt_reg > pth)
                    cnt_next = pth;
                else
                begin
                    cnt_next = sat16(diff);
                    if (cnt_next < 0)
                        ev_next = EV_RELEASE;
                end
            end
        end
        else if (read_clr && ev_reg == EV_RELEASE)
            ev_next = EV_NONE;
        act = tick_en && (ev_next != ev_reg || ev_reg == EV_HOLD);
        if (act)
            chg_next = now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg  <= EV_NONE;
            cnt_reg <= '0;
            chg_reg <= '0;
        end
        else
        begin
            ev_reg  <= ev_next;
            cnt_reg <= cnt_next;
            chg_reg <= chg_next;
        end
    end

    assign stat.ev       = ev_reg;
    assign stat.chg_time = chg_reg;
    assign stat.act      = act;

    // hold is only reached from press
    a_hold_from_press: assert property (@(posedge clk) disable iff (!rst_n)
        ev_reg != EV_HOLD ##1 ev_reg == EV_HOLD |-> $past(ev_reg) == EV_PRESS)
        else $error("hold entered from a state other than press");

    // release only follows press or hold
    a_release_src: assert property (@(posedge clk) disable iff (!rst_n)
        ev_reg != EV_RELEASE ##1 ev_reg == EV_RELEASE |->
            ($past(ev_reg) == EV_PRESS || $past(ev_reg) == EV_HOLD))
        else $error("release entered from none");

    // a read of a released button clears it
    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        read_clr && !tick_en && ev_reg == EV_RELEASE |=> ev_reg == EV_NONE)
        else $error("released button not cleared by read");

endmodule

/* design/mbd_merge.sv */
// Combines lane results: activity OR, read select, activity time, output word.
// Depends on mbd_pkg.
module mbd_merge
    import mbd_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic                  is_read,
    input  logic [IDX_FIELD_W-1:0] key_index,
    input  logic [TIME_W-1:0]     now,
    input  lane_stat_t            stat [NUM_BUTTONS],
    output logic                  in_ready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata
);

    localparam int SEL_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    logic                 valid_reg, valid_next;
    logic [M_DATA_W-1:0]  data_reg, data_next;
    logic [TIME_W-1:0]    act_time_reg, act_time_next;
    logic                 act_any;
    logic                 in_range;
    lane_stat_t           sel;
    event_t               code;
    logic [TIME_W-1:0]    etime;

    always_comb
    begin
        act_any = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++)
            act_any = act_any | stat[i].act;
    end

    assign in_range = key_index < IDX_FIELD_W'(NUM_BUTTONS);
    assign sel      = stat[key_index[SEL_W-1:0]];

    always_comb
    begin
        code  = EV_NONE;
        etime = '0;
        if (is_read && in_range)
        begin
            code  = sel.ev;
            etime = sel.chg_time;
        end
    end

    assign act_time_next = (accept && act_any) ? now : act_time_reg;
    assign in_ready      = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            data_next  = {5'd0, act_time_next, act_any, etime, code};
        end
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            act_time_reg <= '0;
        end
        else
        begin
            valid_reg    <= valid_next;
            act_time_reg <= act_time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    a_act_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept && act_any |=> act_time_reg == $past(now))
        else $error("activity time not refreshed");

    a_read_no_act: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_read |=> m_tdata[TIME_W+2] == 1'b0)
        else $error("activity flagged on a read");

    a_tick_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_read |=> m_tdata[1:0] == EV_NONE)
        else $error("event code on a tick");

endmodule

/* design/multi_button_press_hold_debouncer.sv */
// Channel  Dir  Payload
// s_*      in   tdata: now_ms[31:0], levels[39:32], key_index[47:40]; tuser: req_type
// m_*      out  tdata: event_code[1:0], event_time[33:2], activity[34], last_activity_time[66:35]
// cfg_*    in   index 0 press_threshold, 1 hold_threshold (15 bits)
//
// One word per cycle while s_tready is high; the result is registered and appears in the cycle after accept.
// On a tick with a new time, all buttons update in parallel lanes in the accept cycle.
// Reset clears all button state, tick and activity times; thresholds go to 20/1000.
// s_tready drops only while a result is held and m_tready is low.
// Top level of the debouncer; depends on mbd_pkg, mbd_lane, mbd_merge.
module multi_button_press_hold_debouncer
    import mbd_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // now_ms, levels, key_index
    input  logic                 s_tuser,   // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // event_code, event_time, activity, last_activity_time
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [TH_W-1:0]      cfg_wdata
);

    logic [TH_W-1:0]        press_th_reg, hold_th_reg;
    logic [TIME_W-1:0]      prev_time_reg, prev_time_next;
    logic                   accept, is_read, tick_en;
    logic [TIME_W-1:0]      now;
    logic [LEVEL_BITS-1:0]  levels;
    logic [IDX_FIELD_W-1:0] key_index;
    logic [CNT_W-1:0]       d;
    logic [TIME_W-1:0]      tdiff;
    lane_stat_t             stat [NUM_BUTTONS];

    assign now       = s_tdata[TIME_W-1:0];
    assign levels    = s_tdata[TIME_W+LEVEL_BITS-1:TIME_W];
    assign key_index = s_tdata[TIME_W+LEVEL_BITS+IDX_FIELD_W-1:TIME_W+LEVEL_BITS];
    assign accept    = s_tvalid && s_tready;
    assign is_read   = s_tuser == REQ_READ;
    assign tick_en   = accept && !is_read && (now != prev_time_reg);
    assign tdiff     = now - prev_time_reg;
    assign d         = tdiff[CNT_W-1:0];
    assign prev_time_next = tick_en ? now : prev_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_th_reg  <= PRESS_TH_RST;
            hold_th_reg   <= HOLD_TH_RST;
            prev_time_reg <= '0;
        end
        else
        begin
            prev_time_reg <= prev_time_next;
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_PRESS_TH: press_th_reg <= cfg_wdata;
                    REG_HOLD_TH:  hold_th_reg  <= cfg_wdata;
                    default:      ;
                endcase
            end
        end
    end

    for (genvar b = 0; b < NUM_BUTTONS; b++)
    begin : g_lane
        logic pressed;
        logic read_clr;

        if (b < LEVEL_BITS)
        begin : g_lvl
            assign pressed = levels[b];
        end
        else
        begin : g_nolvl
            assign pressed = 1'b0;
        end

        assign read_clr = accept && is_read && (key_index == IDX_FIELD_W'(b));

        mbd_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .tick_en  (tick_en),
            .read_clr (read_clr),
            .pressed  (pressed),
            .d        (d),
            .now      (now),
            .press_th (press_th_reg),
            .hold_th  (hold_th_reg),
            .stat     (stat[b])
        );
    end

    mbd_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .is_read   (is_read),
        .key_index (key_index),
        .now       (now),
        .stat      (stat),
        .in_ready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for multi_button_press_hold_debouncer: a scoreboard class predicts each
// result word from the accepted input words; tasks drive the input, an always block m_tready.
// Depends on mbd_pkg and the debouncer RTL.

import mbd_pkg::*;

class debounce_scoreboard;
    typedef struct packed {
        logic [1:0]        code;
        logic [TIME_W-1:0] etime;
        logic              act;
        logic [TIME_W-1:0] last_act;
    } reply_t;

    event_t                  key_ev  [NUM_BUTTONS_DEF];
    logic signed [CNT_W-1:0] key_cnt [NUM_BUTTONS_DEF];
    logic [TIME_W-1:0]       key_chg [NUM_BUTTONS_DEF];
    logic [TIME_W-1:0]       prev_tick;
    logic [TIME_W-1:0]       act_time;
    logic [TH_W-1:0]         press_th;
    logic [TH_W-1:0]         hold_th;
    reply_t                  replies_q[$];
    int                      mismatches;

    function new();
        for (int b = 0; b < NUM_BUTTONS_DEF; b++)
        begin
            key_ev[b]  = EV_NONE;
            key_cnt[b] = '0;
            key_chg[b] = '0;
        end
        prev_tick  = '0;
        act_time   = '0;
        press_th   = PRESS_TH_RST;
        hold_th    = HOLD_TH_RST;
        mismatches = 0;
    endfunction

    function logic signed [CNT_W-1:0] clamp_cnt(int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[CNT_W-1:0];
    endfunction

    function void set_threshold(cfg_reg_t r, logic [TH_W-1:0] v);
        if (r == REG_PRESS_TH)
            press_th = v;
        else
            hold_th = v;
    endfunction

    function void note_word(req_t req, logic [TIME_W-1:0] now, logic [7:0] lv,
                            logic [7:0] idx);
        reply_t rep;
        int     d;
        event_t old;
        rep = '0;
        if (req == REQ_TICK)
        begin
            if (now != prev_tick)
            begin
                d = int'((now - prev_tick) & 32'hFFFF);
                prev_tick = now;
                for (int b = 0; b < NUM_BUTTONS_DEF; b++)
                begin
                    old = key_ev[b];
                    if (lv[b])
                    begin
                        if (old == EV_NONE || old == EV_RELEASE)
                        begin
                            key_cnt[b] = clamp_cnt(int'(key_cnt[b]) + d);
                            if (int'(key_cnt[b]) > int'(press_th))
                                key_ev[b] = EV_PRESS;
                        end
                        else if (old == EV_PRESS)
                        begin
                            key_cnt[b] = clamp_cnt(int'(key_cnt[b]) + d);
                            if (int'(key_cnt[b]) > int'(hold_th))
                                key_ev[b] = EV_HOLD;
                        end
                    end
                    else if (old == EV_PRESS || old == EV_HOLD)
                    begin
                        if (int'(key_cnt[b]) > int'(press_th))
                            key_cnt[b] = signed'({1'b0, press_th});
                        else
                        begin
                            key_cnt[b] = clamp_cnt(int'(key_cnt[b]) - d);
                            if (key_cnt[b] < 0)
                                key_ev[b] = EV_RELEASE;
                        end
                    end
                    if (old != key_ev[b] || old == EV_HOLD)
                    begin
                        key_chg[b] = now;
                        act_time   = now;
                        rep.act    = 1'b1;
                    end
                end
            end
        end
        else if (idx < NUM_BUTTONS_DEF)
        begin
            rep.code  = key_ev[idx];
            rep.etime = key_chg[idx];
            // a release is reported once
            if (key_ev[idx] == EV_RELEASE)
                key_ev[idx] = EV_NONE;
        end
        rep.last_act = act_time;
        replies_q.push_back(rep);
    endfunction

    function void check_word(logic [M_DATA_W-1:0] data);
        reply_t want;
        reply_t got;
        got.code     = data[1:0];
        got.etime    = data[33:2];
        got.act      = data[34];
        got.last_act = data[66:35];
        if (replies_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result word %h", data);
            return;
        end
        want = replies_q.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("bad word: code %0d/%0d time %h/%h act %b/%b last %h/%h (exp/act)",
                         want.code, got.code, want.etime, got.etime,
                         want.act, got.act, want.last_act, got.last_act);
        end
    endfunction

    function int pending();
        return replies_q.size();
    endfunction
endclass

module tb_top;

    localparam int STALL_LIMIT = 5000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;  // now_ms, levels, key_index
    logic                s_tuser   = 1'b0; // req_type
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // event_code, event_time, activity, last_activity_time
    logic                cfg_we    = 1'b0;
    logic                cfg_addr  = 1'b0;
    logic [TH_W-1:0]     cfg_wdata = '0;

    debounce_scoreboard sb;
    int                 s_idle_pct  = 36;
    int                 m_idle_pct  = 69;
    int                 stall_cycles = 0;
    logic [TIME_W-1:0]  tnow   = '0;
    logic [7:0]         cur_lv = '0;

    multi_button_press_hold_debouncer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata);
            m_tready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("multi_button_press_hold_debouncer: mismatch");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_word(req_t req, logic [TIME_W-1:0] now, logic [7:0] lv,
                             logic [7:0] idx);
        while ($urandom_range(99) < s_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {idx, lv, now};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_word(req, now, lv, idx);
    endtask

    task automatic send_tick(logic [TIME_W-1:0] now, logic [7:0] lv);
        tnow   = now;
        cur_lv = lv;
        send_word(REQ_TICK, now, lv, 8'($urandom));
    endtask

    task automatic send_read(logic [7:0] idx);
        send_word(REQ_READ, $urandom, 8'($urandom), idx);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_thresholds(logic [TH_W-1:0] press, logic [TH_W-1:0] hold);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_PRESS_TH;
        cfg_wdata <= press;
        @(posedge clk);
        cfg_addr  <= REG_HOLD_TH;
        cfg_wdata <= hold;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_threshold(REG_PRESS_TH, press);
        sb.set_threshold(REG_HOLD_TH, hold);
    endtask

    // mostly held levels with slow flips and short steps, plus odd steps and reads
    task automatic random_words(int count, int step_max);
        int                k;
        logic [TIME_W-1:0] step;
        logic [7:0]        lv;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 30)
            begin
                if ($urandom_range(9) == 0)
                    send_read(8'($urandom));
                else
                    send_read(8'($urandom_range(NUM_BUTTONS_DEF - 1)));
            end
            else
            begin
                k = $urandom_range(99);
                if (k < 5)
                    step = '0;
                else if (k < 8)
                    step = 32'h10000 * $urandom_range(1, 3);
                else if (k < 12)
                    step = $urandom;
                else
                    step = $urandom_range(1, step_max);
                lv = cur_lv;
                if ($urandom_range(19) == 0)
                    lv = 8'($urandom);
                else
                    for (int b = 0; b < 8; b++)
                        if ($urandom_range(99) < 6)
                            lv[b] = ~lv[b];
                send_tick(tnow + step, lv);
            end
        end
    endtask

    task automatic run_phase(logic [TH_W-1:0] press, logic [TH_W-1:0] hold, int count);
        wait_drained();
        write_thresholds(press, hold);
        random_words(count, int'(hold) / 4 + 8);
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_read(0);
        send_read(8'(NUM_BUTTONS_DEF - 1));
        send_read(8'(NUM_BUTTONS_DEF));
        send_read(8'hFF);
        send_tick(32'h0000_0000, 8'hFF);   // same time as reset: ignored
        send_tick(32'h0000_0005, 8'hFF);
        send_tick(32'h0000_001E, 8'hFF);   // over press threshold
        send_read(0);
        send_tick(32'h0000_001E, 8'h00);   // ignored
        send_tick(32'h0001_001E, 8'hFF);   // 64k step adds nothing
        send_tick(32'h0001_0440, 8'hFF);   // over hold threshold
        send_tick(32'h0001_0441, 8'h0F);   // 0-3 hold, 4-7 clamped
        send_tick(32'h0001_0460, 8'h0F);   // 4-7 release
        send_read(4);
        send_read(4);
        send_read(2);
        send_tick(32'hFFFF_FFFF, 8'h00);
        send_tick(32'h7FFF_F000, 8'hAA);   // saturates both ways
        send_tick(32'h8000_EFFF, 8'h55);
        send_read(0);
        send_read(1);
        send_read(5);
        random_words(140, 258);

        run_phase(15'd0, 15'd0, 150);
        s_idle_pct = 69;
        m_idle_pct = 36;
        run_phase(15'd32767, 15'd32767, 150);
        run_phase(15'd3, 15'd60, 150);
        s_idle_pct = 0;
        m_idle_pct = 0;
        run_phase(15'd0, 15'd32767, 150);
        run_phase(15'd20, 15'd1000, 150);

        wait_drained();
        repeat (4) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("multi_button_press_hold_debouncer: match");
        else
            $display("multi_button_press_hold_debouncer: mismatch");
        $finish;
    end

endmodule
